// File: rtl/ifs_pkg.sv
// ----------------------------------------------------------------------------
// ifs_pkg
// Types and signature tables shared by the image format sniffer modules.
// ----------------------------------------------------------------------------
package ifs_pkg;

  localparam int NumSig = 10;
  localparam int SigBytes = 12;
  localparam logic [3:0] PosSat = 4'd12;
  localparam logic [3:0] WalkStart = 4'd8;

  typedef logic [3:0] pos_t;

  typedef enum logic [2:0] {
    FMT_UNKNOWN = 3'd0,
    FMT_PNG     = 3'd1,
    FMT_JPEG    = 3'd2,
    FMT_WEBP    = 3'd3,
    FMT_GIF     = 3'd4,
    FMT_QOI     = 3'd5,
    FMT_JPEGXL  = 3'd6,
    FMT_TIFF    = 3'd7
  } format_t;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_SKIP = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    VD_UNDECIDED = 2'd0,
    VD_ANIMATED  = 2'd1,
    VD_STILL     = 2'd2
  } verdict_t;

  localparam int SIG_PNG     = 0;
  localparam int SIG_JPEG    = 1;
  localparam int SIG_RIFF    = 2;
  localparam int SIG_WEBP    = 3;
  localparam int SIG_GIF     = 4;
  localparam int SIG_QOI     = 5;
  localparam int SIG_JXL_BOX = 6;
  localparam int SIG_JXL_CS  = 7;
  localparam int SIG_TIFF_LE = 8;
  localparam int SIG_TIFF_BE = 9;

  // expected byte at each absolute file offset
  localparam logic [7:0] SIG_VAL [NumSig][SigBytes] = '{
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h57, 8'h45, 8'h42, 8'h50},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h71, 8'h6F, 8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h0C, 8'h4A, 8'h58, 8'h4C, 8'h20,
      8'h0D, 8'h0A, 8'h87, 8'h0A},
    '{8'hFF, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00}
  };

  // offsets each signature covers, bit j = offset j
  localparam logic [SigBytes-1:0] SIG_CARE [NumSig] = '{
    12'h0FF, 12'h007, 12'h00F, 12'hF00, 12'h00F,
    12'h00F, 12'hFFF, 12'h003, 12'h00F, 12'h00F
  };

  // file length needed for a full signature
  localparam pos_t SIG_END [NumSig] = '{
    4'd8, 4'd3, 4'd4, 4'd12, 4'd4, 4'd4, 4'd12, 4'd2, 4'd4, 4'd4
  };

  localparam logic [7:0] ACTL_TAG [4] = '{8'h61, 8'h63, 8'h54, 8'h4C};
  localparam logic [7:0] IDAT_TAG [4] = '{8'h49, 8'h44, 8'h41, 8'h54};

  typedef struct packed {
    logic step;
    logic clear;
  } walk_ctl_t;

endpackage

// File: rtl/ifs_chunk_walk.sv
// ----------------------------------------------------------------------------
// ifs_chunk_walk
// PNG chunk walker: reads length and type, skips body and CRC, and decides
// whether acTL comes before IDAT.
// ----------------------------------------------------------------------------
module ifs_chunk_walk (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ifs_pkg::walk_ctl_t     ctl,
  input  logic [7:0]             byte_value,
  output logic                   animated
);

  ifs_pkg::phase_t   phase_r, phase_nxt;
  ifs_pkg::verdict_t verdict_r, verdict_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [32:0]       skip_r, skip_nxt;
  logic [1:0]        type_r, type_nxt;

  always_comb begin
    phase_nxt   = phase_r;
    verdict_nxt = verdict_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    skip_nxt    = skip_r;
    type_nxt    = type_r;
    if (ctl.step && verdict_r == ifs_pkg::VD_UNDECIDED) begin
      case (phase_r)
        ifs_pkg::PH_LEN: begin
          len_nxt = {len_r[23:0], byte_value};
          if (cnt_r == 2'd3) begin
            cnt_nxt   = 2'd0;
            phase_nxt = ifs_pkg::PH_TYPE;
            type_nxt  = 2'b11;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
        ifs_pkg::PH_TYPE: begin
          if (byte_value != ifs_pkg::ACTL_TAG[cnt_r]) type_nxt[0] = 1'b0;
          if (byte_value != ifs_pkg::IDAT_TAG[cnt_r]) type_nxt[1] = 1'b0;
          if (cnt_r == 2'd3) begin
            cnt_nxt = 2'd0;
            if (type_nxt[0]) begin
              verdict_nxt = ifs_pkg::VD_ANIMATED;
            end else if (type_nxt[1]) begin
              verdict_nxt = ifs_pkg::VD_STILL;
            end else begin
              skip_nxt  = {1'b0, len_r} + 33'd4;
              len_nxt   = 32'd0;
              phase_nxt = ifs_pkg::PH_SKIP;
            end
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
        ifs_pkg::PH_SKIP: begin
          if (skip_r != 33'd0) skip_nxt = skip_r - 33'd1;
          if (skip_nxt == 33'd0) begin
            phase_nxt = ifs_pkg::PH_LEN;
            cnt_nxt   = 2'd0;
            len_nxt   = 32'd0;
          end
        end
        default: begin
          phase_nxt = ifs_pkg::PH_LEN;
        end
      endcase
    end
  end

  assign animated = (verdict_nxt == ifs_pkg::VD_ANIMATED);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      phase_r   <= ifs_pkg::PH_LEN;
      verdict_r <= ifs_pkg::VD_UNDECIDED;
      cnt_r     <= 2'd0;
      len_r     <= 32'd0;
      skip_r    <= 33'd0;
      type_r    <= 2'b11;
    end else if (ctl.step) begin
      phase_r   <= phase_nxt;
      verdict_r <= verdict_nxt;
      cnt_r     <= cnt_nxt;
      len_r     <= len_nxt;
      skip_r    <= skip_nxt;
      type_r    <= type_nxt;
    end
  end

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ifs_pkg::PH_SKIP |-> skip_r != 33'd0)
    else $error("skip phase with empty skip count");

  a_verdict_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    verdict_r != ifs_pkg::VD_UNDECIDED && !ctl.clear |=> $stable(verdict_r))
    else $error("walk verdict changed before end of file");

  a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> phase_r == ifs_pkg::PH_LEN && verdict_r == ifs_pkg::VD_UNDECIDED)
    else $error("walker not restarted after end of file");

endmodule

// File: rtl/image_format_sniffer.sv
// ----------------------------------------------------------------------------
// image_format_sniffer
// Detects an image file format from its leading signature bytes and reports
// whether a PNG is animated (acTL chunk before IDAT).
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_byte_value, in_last_byte
//  out     | output    | out_valid, out_stall, out_format_code, out_animated_png
//
//  One byte per cycle is accepted, back to back, while in_stall is low.
//  A byte is held in the input register, and the result of the final byte
//  is then registered in the output register.
//  Synchronous active-low reset; after the final byte the block restarts.
//  in_stall rises only while a final byte waits for a stalled output register.
// ----------------------------------------------------------------------------
module image_format_sniffer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_format_code,
  output logic       out_animated_png
);

  logic                       s1_valid_r;
  logic [7:0]                 s1_byte_r;
  logic                       s1_last_r;
  logic                       s1_proc;
  logic                       in_xfer;
  ifs_pkg::pos_t              pos_r, len_nxt;
  logic [ifs_pkg::NumSig-1:0] alive_r, alive_nxt, sig_hit;
  ifs_pkg::format_t           code_nxt;
  ifs_pkg::walk_ctl_t         walk_ctl;
  logic                       walk_anim;
  logic                       out_valid_r;
  ifs_pkg::format_t           out_code_r;
  logic                       out_anim_r;

  assign s1_proc  = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_proc;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_last_byte;
    end
  end

  always_comb begin
    alive_nxt = alive_r;
    for (int i = 0; i < ifs_pkg::NumSig; i++) begin
      if (pos_r < ifs_pkg::PosSat && ifs_pkg::SIG_CARE[i][pos_r] &&
          ifs_pkg::SIG_VAL[i][pos_r] != s1_byte_r) begin
        alive_nxt[i] = 1'b0;
      end
    end
    len_nxt = (pos_r < ifs_pkg::PosSat) ? pos_r + 4'd1 : ifs_pkg::PosSat;
    for (int i = 0; i < ifs_pkg::NumSig; i++) begin
      sig_hit[i] = alive_nxt[i] && (len_nxt >= ifs_pkg::SIG_END[i]);
    end
  end

  always_comb begin
    if (sig_hit[ifs_pkg::SIG_PNG]) begin
      code_nxt = ifs_pkg::FMT_PNG;
    end else if (sig_hit[ifs_pkg::SIG_JPEG]) begin
      code_nxt = ifs_pkg::FMT_JPEG;
    end else if (sig_hit[ifs_pkg::SIG_RIFF] && sig_hit[ifs_pkg::SIG_WEBP]) begin
      code_nxt = ifs_pkg::FMT_WEBP;
    end else if (sig_hit[ifs_pkg::SIG_GIF]) begin
      code_nxt = ifs_pkg::FMT_GIF;
    end else if (sig_hit[ifs_pkg::SIG_QOI]) begin
      code_nxt = ifs_pkg::FMT_QOI;
    end else if (sig_hit[ifs_pkg::SIG_JXL_BOX] || sig_hit[ifs_pkg::SIG_JXL_CS]) begin
      code_nxt = ifs_pkg::FMT_JPEGXL;
    end else if (sig_hit[ifs_pkg::SIG_TIFF_LE] || sig_hit[ifs_pkg::SIG_TIFF_BE]) begin
      code_nxt = ifs_pkg::FMT_TIFF;
    end else begin
      code_nxt = ifs_pkg::FMT_UNKNOWN;
    end
  end

  assign walk_ctl.step  = s1_proc && (pos_r >= ifs_pkg::WalkStart);
  assign walk_ctl.clear = s1_proc && s1_last_r;

  ifs_chunk_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (walk_ctl),
    .byte_value (s1_byte_r),
    .animated   (walk_anim)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 4'd0;
      alive_r <= '1;
    end else if (s1_proc) begin
      if (s1_last_r) begin
        pos_r   <= 4'd0;
        alive_r <= '1;
      end else begin
        pos_r   <= len_nxt;
        alive_r <= alive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_proc && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_proc && s1_last_r) begin
      out_code_r <= code_nxt;
      out_anim_r <= (code_nxt == ifs_pkg::FMT_PNG) && walk_anim;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_format_code  = out_code_r;
  assign out_animated_png = out_anim_r;

  a_anim_only_png: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_anim_r |-> out_code_r == ifs_pkg::FMT_PNG)
    else $error("animated flag on a non-PNG result");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= ifs_pkg::PosSat)
    else $error("byte position beyond saturation");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_proc && s1_last_r |=> pos_r == 4'd0 && alive_r == '1)
    else $error("signature state not restarted after final byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r && out_valid_r)
    else $error("input stalled without a pending final byte");

endmodule
